FILE: hdl/pcbez_pkg.sv
// Shared types, codes and arithmetic helpers for the piecewise cubic Bezier evaluator.
`default_nettype none
package pcbez_pkg;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_POINT = 2'd1;
    localparam logic [1:0] FUNC_DERIV = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic REG_SEC_COUNT    = 1'b0;
    localparam logic REG_REVERSE_MODE = 1'b1;

    localparam int QDEPTH = 4;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_POINT = 2'd1,
        K_DERIV = 2'd2
    } t_kind;

    // One queued transfer from front to back.
    typedef struct packed {
        t_kind              kind;
        logic [4:0]         sec;
        logic [1:0]         slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [16:0]        t;
        logic               neg;
    } t_qent;

    // Divide by 2^s, rounding half away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic signed [63:0] h;
        h = 64'sd1 <<< (s - 1);
        if (v >= 0) begin
            return (v + h) >>> s;
        end else begin
            return -((-v + h) >>> s);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: hdl/pcbez_if.sv
// Input and result channel interfaces of the Bezier evaluator.
`default_nettype none
interface pcbez_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [3:0]  section_sel;
    logic [1:0]  point_slot;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
    logic [16:0] param_global;

    modport source(output valid, func, section_sel, point_slot, load_x, load_y, load_z,
                   param_global, input ready);
    modport sink(input valid, func, section_sel, point_slot, load_x, load_y, load_z,
                 param_global, output ready);
endinterface

interface pcbez_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;

    modport source(output valid, res_x, res_y, res_z, input ready);
    modport sink(input valid, res_x, res_y, res_z, output ready);
endinterface
`default_nettype wire

FILE: hdl/piecewise_cubic_bezier_eval_unit.sv
// Piecewise cubic Bezier evaluator, top level.
//
// Channels: i_in carries load and evaluate items (valid/ready, a transfer when
// both are high); o_out returns one result per evaluate, none per load.
// APB-style port: section count at 0x0, reverse mode at 0x4; pready tied high.
// Front end classifies each item and maps tg to section and local t in the
// accepting cycle, then pushes it into a 4-entry queue. The back end pops one
// entry a cycle while the output does not stall: loads write the per-slot control
// point banks, evaluates run a six-stage pipeline (bank read and squares, weight
// products, weight rounding, twelve 32x32 products, sums, rounding and
// saturation into the output reg). Throughput: one item per cycle while the
// output does not stall, limited by the single pipeline issue slot.
// Loads travel through the same queue, so evaluates see every earlier load.
// When the receiver stalls, the whole back pipeline holds; the queue absorbs up
// to four further items before i_in.ready drops.
// Reset (synchronous, active low) empties the queue and pipeline, sets the
// section count to 1 and clears reverse mode; control point banks are not cleared.
`default_nettype none
module piecewise_cubic_bezier_eval_unit
    import pcbez_pkg::*;
#(
    parameter int MAX_SECTIONS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pcbez_in_if.sink         i_in,
    pcbez_out_if.source      o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic  push, pop, empty, full;
    t_qent entry, head;

    pcbez_front #(.MAX_SECTIONS(MAX_SECTIONS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    pcbez_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    pcbez_back #(.MAX_SECTIONS(MAX_SECTIONS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire

FILE: hdl/pcbez_front.sv
// Front end: configuration registers, item classification and section/local-t mapping.
`default_nettype none
module pcbez_front
    import pcbez_pkg::*;
#(
    parameter int MAX_SECTIONS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    pcbez_in_if.sink         i_in,
    input  wire logic        i_full,
    output logic             o_push,
    output t_qent            o_entry
);
    localparam int NMAX = (MAX_SECTIONS > 31) ? 31 : MAX_SECTIONS;

    logic [4:0] r_sec_count;
    logic       r_reverse;
    logic       wr_en;

    logic [4:0]         n_eff;
    logic signed [18:0] tgs;
    logic signed [24:0] tc;
    logic [20:0]        end_v;
    logic [20:0]        tcc;
    logic [4:0]         sec;
    logic               at_end;
    logic               is_load;
    logic               load_ok;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_count <= 5'd1;
            r_reverse   <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SEC_COUNT:    r_sec_count <= pwdata[4:0];
                REG_REVERSE_MODE: r_reverse   <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SEC_COUNT:    prdata = {27'd0, r_sec_count};
            REG_REVERSE_MODE: prdata = {31'd0, r_reverse};
        endcase
    end

    // Section count clamped into 1..NMAX (MAX_SECTIONS, capped at 31).
    always_comb begin
        if (r_sec_count == 5'd0) begin
            n_eff = 5'd1;
        end else if (int'(r_sec_count) > NMAX) begin
            n_eff = 5'(NMAX);
        end else begin
            n_eff = r_sec_count;
        end
    end

    always_comb begin
        tgs = r_reverse ? (19'sd65536 - $signed({2'b00, i_in.param_global}))
                        : $signed({2'b00, i_in.param_global});
        tc    = $signed({{6{tgs[18]}}, tgs}) * $signed({20'd0, n_eff});
        end_v = {n_eff, 16'd0};
        if (tc < 0) begin
            tcc = 21'd0;
        end else if (tc > $signed({4'd0, end_v})) begin
            tcc = end_v;
        end else begin
            tcc = tc[20:0];
        end
        at_end = (tcc == end_v);
        sec    = (tcc[20:16] >= n_eff) ? (n_eff - 5'd1) : tcc[20:16];
    end

    assign is_load  = (i_in.func == FUNC_LOAD);
    assign load_ok  = (int'(i_in.section_sel) < MAX_SECTIONS);
    assign i_in.ready = !i_full;

    // Unused code and out-of-table loads are dropped here.
    assign o_push = i_in.valid && i_in.ready && (i_in.func != FUNC_NONE)
                    && (!is_load || load_ok);

    always_comb begin
        o_entry.kind = is_load ? K_LOAD : ((i_in.func == FUNC_DERIV) ? K_DERIV : K_POINT);
        o_entry.sec  = is_load ? {1'b0, i_in.section_sel} : sec;
        o_entry.slot = i_in.point_slot;
        o_entry.x    = i_in.load_x;
        o_entry.y    = i_in.load_y;
        o_entry.z    = i_in.load_z;
        o_entry.t    = at_end ? ONE_Q16 : {1'b0, tcc[15:0]};
        o_entry.neg  = r_reverse && (i_in.func == FUNC_DERIV);
    end
endmodule
`default_nettype wire

FILE: hdl/pcbez_queue.sv
// Short FIFO decoupling the front end from the evaluation pipeline.
`default_nettype none
module pcbez_queue
    import pcbez_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_qent      i_entry,
    input  wire logic  i_pop,
    output t_qent      o_head,
    output logic       o_empty,
    output logic       o_full
);
    localparam int PW = $clog2(QDEPTH);

    t_qent           r_q [QDEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

FILE: hdl/pcbez_back.sv
// Back end: control point banks and the Bernstein weight / dot product pipeline.
`default_nettype none
module pcbez_back
    import pcbez_pkg::*;
#(
    parameter int MAX_SECTIONS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_qent      i_head,
    input  wire logic  i_empty,
    output logic       o_pop,
    pcbez_out_if.source o_out
);
    localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    logic          en;
    logic [SW-1:0] addr;
    logic          wr;

    logic [95:0] r_rd [4];

    // stage 1
    logic        r_s1_v, r_s1_d, r_s1_neg;
    logic [16:0] r_s1_t, r_s1_a;
    logic [33:0] r_s1_t2, r_s1_a2, r_s1_ta;
    logic [16:0] a0;
    // stage 2
    logic        r_s2_v, r_s2_d, r_s2_neg;
    logic signed [63:0] r_s2_w [4];
    logic signed [63:0] n_s2_w [4];
    logic [95:0] r_s2_cp [4];
    // stage 3
    logic        r_s3_v, r_s3_neg;
    logic signed [31:0] r_s3_w [4];
    logic [95:0] r_s3_cp [4];
    // stage 4
    logic        r_s4_v, r_s4_neg;
    logic signed [63:0] r_s4_p [3][4];
    // stage 5
    logic        r_s5_v;
    logic signed [63:0] r_s5_acc [3];
    logic signed [63:0] n_s5_acc [3];
    // output
    logic        r_out_v;
    logic signed [31:0] r_res [3];

    assign en    = !r_out_v || o_out.ready;
    assign o_pop = en && !i_empty;
    assign wr    = o_pop && (i_head.kind == K_LOAD);
    assign addr  = SW'(i_head.sec);
    assign a0    = ONE_Q16 - i_head.t;

    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [95:0] r_mem [MAX_SECTIONS];
        always_ff @(posedge i_clk) begin
            if (wr && (i_head.slot == 2'(g))) begin
                r_mem[addr] <= {i_head.z, i_head.y, i_head.x};
            end
            if (en) begin
                r_rd[g] <= r_mem[addr];
            end
        end
    end

    // Raw weights: point form in Q.48, derivative form in Q.32.
    always_comb begin
        logic [50:0] m0, m1, m2, m3;
        logic signed [63:0] t2s, a2s, t16;
        m0  = r_s1_a2 * r_s1_a;
        m1  = r_s1_ta * r_s1_a;
        m2  = r_s1_t2 * r_s1_a;
        m3  = r_s1_t2 * r_s1_t;
        t2s = $signed({30'd0, r_s1_t2});
        a2s = $signed({30'd0, r_s1_a2});
        t16 = $signed({31'd0, r_s1_t, 16'd0});
        if (r_s1_d) begin
            n_s2_w[0] = -(a2s * 3);
            n_s2_w[1] = t2s * 9 - t16 * 12 + (64'sd3 <<< 32);
            n_s2_w[2] = -(t2s * 9) + t16 * 6;
            n_s2_w[3] = t2s * 3;
        end else begin
            n_s2_w[0] = $signed({13'd0, m0});
            n_s2_w[1] = $signed({13'd0, m1}) * 3;
            n_s2_w[2] = $signed({13'd0, m2}) * 3;
            n_s2_w[3] = $signed({13'd0, m3});
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_s5_acc[j] = r_s4_p[j][0] + r_s4_p[j][1] + r_s4_p[j][2] + r_s4_p[j][3];
            if (r_s4_neg) begin
                n_s5_acc[j] = -n_s5_acc[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_d   <= (i_head.kind == K_DERIV);
            r_s1_neg <= i_head.neg;
            r_s1_t   <= i_head.t;
            r_s1_a   <= a0;
            r_s1_t2  <= i_head.t * i_head.t;
            r_s1_a2  <= a0 * a0;
            r_s1_ta  <= i_head.t * a0;

            r_s2_d   <= r_s1_d;
            r_s2_neg <= r_s1_neg;
            r_s2_w   <= n_s2_w;
            r_s2_cp  <= r_rd;

            r_s3_neg <= r_s2_neg;
            for (int k = 0; k < 4; k++) begin
                r_s3_w[k] <= 32'(rnd_shift(r_s2_w[k], r_s2_d ? 4 : 20));
            end
            r_s3_cp  <= r_s2_cp;

            r_s4_neg <= r_s3_neg;
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 4; k++) begin
                    r_s4_p[j][k] <= r_s3_w[k] * $signed(r_s3_cp[k][32*j +: 32]);
                end
            end

            r_s5_acc <= n_s5_acc;

            for (int j = 0; j < 3; j++) begin
                r_res[j] <= sat32(rnd_shift(r_s5_acc[j], 28));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= o_pop && (i_head.kind != K_LOAD);
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_s5_v  <= r_s4_v;
            r_out_v <= r_s5_v;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.res_x = r_res[0];
    assign o_out.res_y = r_res[1];
    assign o_out.res_z = r_res[2];
endmodule
`default_nettype wire

FILE: hdl/pcbez_chk.sv
// Port-level checker for the Bezier evaluator, bound to the top level.
`default_nettype none
module pcbez_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [95:0] i_out_data,
    input wire logic        i_pready
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("pready low");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result changed under stall");
endmodule

bind piecewise_cubic_bezier_eval_unit pcbez_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  ({o_out.res_z, o_out.res_y, o_out.res_x}),
    .i_pready    (pready)
);
`default_nettype wire

FILE: sim/piecewise_cubic_bezier_eval_unit_tb.sv
// Self-checking testbench for the piecewise cubic Bezier evaluator.
`default_nettype none
module piecewise_cubic_bezier_eval_unit_tb
    import pcbez_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  func;
        logic [3:0]  sel;
        logic [1:0]  slot;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [16:0] tg;
        bit          known;   // expected result typed into the row
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
    } t_row;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_vec;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pcbez_in_if  in_ch();
    pcbez_out_if out_ch();

    piecewise_cubic_bezier_eval_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the block: control point table and the two registers.
    longint cp_tab [64][3];
    bit     cp_written [64];
    int     sec_count_sh;
    bit     reverse_sh;

    t_vec   expected_pts[$];
    int     fail_count = 0;
    int     src_idle_pct = 35, snk_idle_pct = 83;
    bit     hold_off = 1'b0;

    function automatic longint round_away(longint v, int s);
        longint h;
        h = longint'(1) <<< (s - 1);
        if (v >= 0) begin
            return (v + h) >>> s;
        end
        return -((-v + h) >>> s);
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // Effective section count as the block sees it.
    function automatic int eff_sections();
        int n;
        n = sec_count_sh;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        return n;
    endfunction

    // Section a given tg lands in, for keeping reads inside the written table.
    function automatic int section_of(logic [16:0] tg);
        longint n, tgs, tc;
        n = eff_sections();
        tgs = tg;
        if (reverse_sh) tgs = 65536 - tgs;
        tc = tgs * n;
        if (tc < 0) tc = 0;
        if (tc > n * 65536) tc = n * 65536;
        if ((tc >> 16) >= n) return int'(n - 1);
        return int'(tc >> 16);
    endfunction

    function automatic t_vec curve_eval(logic [1:0] func, logic [16:0] tg);
        longint n, tgs, tc, t, a, t2, acc;
        longint w[4];
        int sec;
        t_vec r;
        logic [31:0] res[3];
        n = eff_sections();
        tgs = tg;
        if (reverse_sh) tgs = 65536 - tgs;
        tc = tgs * n;
        if (tc < 0) tc = 0;
        if (tc > n * 65536) tc = n * 65536;
        sec = section_of(tg);
        t = tc & 64'hFFFF;
        if (tc >= n * 65536) t = 65536;
        a = 65536 - t;
        if (func == FUNC_POINT) begin
            w[0] = round_away(a * a * a, 20);
            w[1] = round_away(3 * t * a * a, 20);
            w[2] = round_away(3 * t * t * a, 20);
            w[3] = round_away(t * t * t, 20);
        end else begin
            t2 = t * t;
            w[0] = round_away(-3 * a * a, 4);
            w[1] = round_away(9 * t2 - 12 * (t <<< 16) + 3 * (longint'(1) <<< 32), 4);
            w[2] = round_away(-9 * t2 + 6 * (t <<< 16), 4);
            w[3] = round_away(3 * t2, 4);
        end
        for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) acc += w[k] * cp_tab[sec * 4 + k][j];
            if (func == FUNC_DERIV && reverse_sh) acc = -acc;
            res[j] = clip32(round_away(acc, 28));
        end
        r.x = res[0]; r.y = res[1]; r.z = res[2];
        return r;
    endfunction

    // Apply an accepted item to the shadow and queue its expected result.
    task automatic apply_item(t_row r);
        t_vec v;
        if (r.func == FUNC_LOAD) begin
            cp_tab[r.sel * 4 + r.slot][0] = longint'(signed'(r.x));
            cp_tab[r.sel * 4 + r.slot][1] = longint'(signed'(r.y));
            cp_tab[r.sel * 4 + r.slot][2] = longint'(signed'(r.z));
            cp_written[r.sel * 4 + r.slot] = 1'b1;
        end else if (r.func != FUNC_NONE) begin
            v = curve_eval(r.func, r.tg);
            if (r.known) begin
                v.x = r.ex; v.y = r.ey; v.z = r.ez;
            end
            expected_pts.push_back(v);
        end
    endtask

    // Drive one item and wait for its transfer; valid stays up for a following item.
    task automatic send_item(t_row r);
        while (($urandom_range(99) < src_idle_pct)) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= r.func;
        in_ch.section_sel  <= r.sel;
        in_ch.point_slot   <= r.slot;
        in_ch.load_x       <= r.x;
        in_ch.load_y       <= r.y;
        in_ch.load_z       <= r.z;
        in_ch.param_global <= r.tg;
        do @(posedge i_clk); while (!in_ch.ready);
        apply_item(r);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == 3'd0) sec_count_sh = int'(data[4:0]);
        else reverse_sh = data[0];
    endtask

    // Drain, let loads and ignored items settle, then reconfigure.
    task automatic set_mode(int n, bit rev);
        in_ch.valid <= 1'b0;
        while (expected_pts.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        apb_write(3'd0, n);
        apb_write(3'd4, 32'(rev));
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    function automatic t_row load_row(int sel, int slot, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z);
        t_row r;
        r = '{default: '0};
        r.func = FUNC_LOAD; r.sel = 4'(sel); r.slot = 2'(slot); r.x = x; r.y = y; r.z = z;
        r.tg = 17'($urandom);
        return r;
    endfunction

    function automatic t_row eval_row(logic [1:0] func, logic [16:0] tg);
        t_row r;
        r = '{default: '0};
        r.func = func; r.tg = tg; r.sel = 4'($urandom); r.slot = 2'($urandom);
        r.x = $urandom; r.y = $urandom; r.z = $urandom;
        return r;
    endfunction

    // Random tg: mostly in range, with the ends and over-range values mixed in.
    function automatic logic [16:0] rand_tg();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return ONE_Q16;
            2: return 17'($urandom_range(131071, 65537));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    // Random evaluate; only ever reads a fully written section.
    task automatic send_random_eval();
        logic [16:0] tg;
        int sec;
        bit ok;
        do begin
            tg = rand_tg();
            sec = section_of(tg);
            ok = cp_written[sec*4] && cp_written[sec*4+1] && cp_written[sec*4+2]
                 && cp_written[sec*4+3];
        end while (!ok);
        send_item(eval_row($urandom_range(1) ? FUNC_POINT : FUNC_DERIV, tg));
    endtask

    task automatic random_phase(int items);
        t_row r;
        for (int i = 0; i < items; i++) begin
            case ($urandom_range(9))
                0, 1, 2: send_item(load_row($urandom_range(15), $urandom_range(3),
                                            rand_coord(), rand_coord(), rand_coord()));
                3: begin
                    // ignored code carries random content
                    r = eval_row(FUNC_NONE, 17'($urandom));
                    send_item(r);
                end
                default: send_random_eval();
            endcase
        end
    endtask

    // Directed table: sections 0 and 15 loaded with extremes, then curve ends and edges.
    t_row dir_tab[$];

    initial begin
        t_row r;
        in_ch.valid = 1'b0; in_ch.func = '0; in_ch.section_sel = '0; in_ch.point_slot = '0;
        in_ch.load_x = '0; in_ch.load_y = '0; in_ch.load_z = '0; in_ch.param_global = '0;
        sec_count_sh = 1; reverse_sh = 1'b0;
        foreach (cp_written[i]) cp_written[i] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_tab.push_back(load_row(0, 0, 32'h00010000, 32'h80000000, 32'h7FFFFFFF));
        dir_tab.push_back(load_row(0, 1, 32'h7FFFFFFF, 32'h80000000, 32'h00000000));
        dir_tab.push_back(load_row(0, 2, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF));
        dir_tab.push_back(load_row(0, 3, 32'h00030000, 32'h80000000, 32'h55555555));
        // out-of-table section is not encodable in 4 bits; load all of section 15
        dir_tab.push_back(load_row(15, 0, 32'hAAAAAAAA, 32'h12345678, 32'h0));
        dir_tab.push_back(load_row(15, 1, 32'h0, 32'h0, 32'h0));
        dir_tab.push_back(load_row(15, 2, 32'h0, 32'hFFFFFFFF, 32'h0));
        dir_tab.push_back(load_row(15, 3, 32'h7FFFFFFF, 32'h0, 32'hAAAAAAAA));
        // t = 0 gives p0 exactly
        r = eval_row(FUNC_POINT, 17'd0);
        r.known = 1; r.ex = 32'h00010000; r.ey = 32'h80000000; r.ez = 32'h7FFFFFFF;
        dir_tab.push_back(r);
        // t = 1 gives p3 exactly
        r = eval_row(FUNC_POINT, ONE_Q16);
        r.known = 1; r.ex = 32'h00030000; r.ey = 32'h80000000; r.ez = 32'h55555555;
        dir_tab.push_back(r);
        dir_tab.push_back(eval_row(FUNC_POINT, 17'h1FFFF));   // over range clamps to end
        dir_tab.push_back(eval_row(FUNC_POINT, 17'h08000));
        dir_tab.push_back(eval_row(FUNC_DERIV, 17'd0));       // saturates
        dir_tab.push_back(eval_row(FUNC_DERIV, ONE_Q16));
        dir_tab.push_back(eval_row(FUNC_DERIV, 17'h0FFFF));
        dir_tab.push_back(eval_row(FUNC_NONE, 17'h1FFFF));     // ignored
        foreach (dir_tab[i]) send_item(dir_tab[i]);

        // fill the whole table so every section can be read
        for (int s = 0; s < 16; s++)
            for (int k = 0; k < 4; k++)
                send_item(load_row(s, k, rand_coord(), rand_coord(), rand_coord()));

        // section count zero and above range, reverse on and off
        set_mode(0, 1'b1);
        random_phase(40);
        set_mode(31, 1'b0);
        random_phase(40);
        set_mode(16, 1'b1);
        // long receiver hold-off while items keep coming
        hold_off = 1'b1;
        random_phase(60);
        set_mode(3, 1'b0);
        random_phase(200);
        src_idle_pct = 83; snk_idle_pct = 35;
        set_mode(16, 1'b0);
        random_phase(200);
        src_idle_pct = 0; snk_idle_pct = 0;
        set_mode(1, 1'b1);
        random_phase(100);
        set_mode(7, 1'b1);
        random_phase(150);
        in_ch.valid <= 1'b0;

        while (expected_pts.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial begin
        int held;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                held = 0;
                out_ch.ready <= 1'b0;
                while (held < 300) begin
                    @(posedge i_clk);
                    held++;
                end
                hold_off = 1'b0;
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Result checker, sampled at the clock edge.
    always @(posedge i_clk) begin
        t_vec e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_pts.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                         out_ch.res_x, out_ch.res_y, out_ch.res_z);
                fail_count++;
            end else begin
                e = expected_pts.pop_front();
                if (out_ch.res_x !== e.x || out_ch.res_y !== e.y || out_ch.res_z !== e.z) begin
                    $display("%0t: expected x=%h y=%h z=%h, got x=%h y=%h z=%h", $time,
                             e.x, e.y, e.z, out_ch.res_x, out_ch.res_y, out_ch.res_z);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
